// File: design/ptpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpid_pkg
// Shared codes, types and helpers for the path-tracking PID controller.
// ----------------------------------------------------------------------------
package ptpid_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int ACC_W     = 96;
  localparam int MUL_W     = 33;
  localparam int INT_W     = 48;
  localparam int SQ_STEPS  = 32;
  localparam int SQ_CNT_W  = 5;
  localparam int IHI_SHIFT = 24;

  // opcodes
  localparam logic [1:0] OP_RANGE = 2'd0;
  localparam logic [1:0] OP_POSE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;  // unused code, ignored

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OBST     = 3'd6;

  typedef enum logic [2:0] {
    MUL_DX, MUL_DY, MUL_PE, MUL_ILO, MUL_IHI, MUL_DD
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_ADD_SH
  } acc_op_t;

  typedef struct packed {
    logic     capture;
    logic     geom;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     sq_init;
    logic     sq_step;
    logic     err_arc;
    logic     pid_upd;
    logic     out_load;
    logic     out_zero;
  } cmd_t;

  typedef struct packed {
    logic latched;
    logic arc;
    logic out_full;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF)      r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else                            r = v[31:0];
    return r;
  endfunction

endpackage

// File: design/path_tracking_pid_controller.sv
`timescale 1ns / 1ps
// Range and pose requests are handled while idle; a control tick steps through the
//   geometry, on an arc end the 32-step square root (one radicand bit pair per cycle),
//   and up to six passes through the shared 33x33 multiplier before its result is
//   valid. A latched tick goes straight to the result state and gives zeros.
// Throughput: one request at a time; the result register frees the input side.
// Reset (rst, synchronous): registers to defaults, state and obstacle latch zero.
// ----------------------------------------------------------------------------
// path_tracking_pid_controller
// Stadium-path cross-track error with a saturating PID on the angular rate.
// ----------------------------------------------------------------------------
module path_tracking_pid_controller
  import ptpid_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic [30:0]          range_sample,
  input  logic signed [31:0]   pose_x,
  input  logic signed [31:0]   pose_y,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   linear_velocity,
  output logic signed [31:0]   angular_velocity,
  output logic signed [31:0]   tracking_error,
  output logic                 command_valid
);

  // Controller drives commands; datapath reports latch, arc and result-full.
  cmd_t    cmd;
  status_t status;

  ptpid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // Datapath holds the configuration, pose, latch, integral and result register.
  ptpid_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .opcode           (opcode),
    .range_sample     (range_sample),
    .pose_x           (pose_x),
    .pose_y           (pose_y),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .linear_velocity  (linear_velocity),
    .angular_velocity (angular_velocity),
    .tracking_error   (tracking_error),
    .command_valid    (command_valid)
  );

  // A held result is never dropped.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A tick request takes the sequencer out of idle and so holds the input not ready.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_TICK |=> !in_ready)
    else $error("tick did not occupy the sequencer");

  // Range, pose and unused-code requests leave the input ready in the next cycle.
  a_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode != OP_TICK |=> in_ready)
    else $error("non-tick request stalled the input");

  // Results only carry a valid command when the obstacle latch is clear.
  a_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && status.latched |=> !command_valid)
    else $error("command issued while obstacle latched");

endmodule

// File: design/ptpid_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpid_ctrl
// Sequencer: steps the datapath through geometry, square root and PID.
// ----------------------------------------------------------------------------
module ptpid_ctrl
  import ptpid_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] opcode,
  input  logic       out_ready,
  input  status_t    status,
  output logic       in_ready,
  output cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_GEOM, S_MDX, S_MDY, S_SQADD, S_SQI, S_SQRT, S_SQF,
    S_INT, S_M0, S_M1, S_M2, S_M3, S_M4, S_OUT
  } state_t;

  state_t               state;
  logic [SQ_CNT_W-1:0]  cnt;
  logic                 zero;
  logic                 load_ok;

  assign in_ready = (state == S_IDLE);
  assign load_ok  = !status.out_full || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      zero  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && opcode == OP_TICK) begin
            zero  <= status.latched;
            state <= status.latched ? S_OUT : S_GEOM;
          end
        end
        S_GEOM:  state <= status.arc ? S_MDX : S_INT;
        S_MDX:   state <= S_MDY;
        S_MDY:   state <= S_SQADD;
        S_SQADD: state <= S_SQI;
        S_SQI: begin
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == SQ_CNT_W'(SQ_STEPS - 1)) state <= S_SQF;
        end
        S_SQF: state <= S_INT;
        S_INT: state <= S_M0;
        S_M0:  state <= S_M1;
        S_M1:  state <= S_M2;
        S_M2:  state <= S_M3;
        S_M3:  state <= S_M4;
        S_M4: begin
          zero  <= 1'b0;
          state <= S_OUT;
        end
        S_OUT:   if (load_ok) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MUL_DX;
    cmd.acc_op   = ACC_HOLD;
    cmd.capture  = (state == S_IDLE) && in_valid;
    case (state)
      S_GEOM: cmd.geom = 1'b1;
      S_MDX: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DX;
      end
      S_MDY: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DY; cmd.acc_op = ACC_LOAD;
      end
      S_SQADD: cmd.acc_op = ACC_ADD;
      S_SQI:   cmd.sq_init = 1'b1;
      S_SQRT:  cmd.sq_step = 1'b1;
      S_SQF:   cmd.err_arc = 1'b1;
      S_INT:   cmd.pid_upd = 1'b1;
      S_M0: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_PE;
      end
      S_M1: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_ILO; cmd.acc_op = ACC_LOAD;
      end
      S_M2: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_IHI; cmd.acc_op = ACC_ADD;
      end
      S_M3: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DD; cmd.acc_op = ACC_ADD_SH;
      end
      S_M4: cmd.acc_op = ACC_ADD;
      S_OUT: begin
        cmd.out_load = load_ok;
        cmd.out_zero = zero;
      end
      default: ;
    endcase
  end

endmodule

// File: design/ptpid_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpid_dp
// Datapath: registers, state, shared multiplier, accumulator, square root.
// ----------------------------------------------------------------------------
module ptpid_dp
  import ptpid_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [1:0]           opcode,
  input  logic [30:0]          range_sample,
  input  logic signed [31:0]   pose_x,
  input  logic signed [31:0]   pose_y,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic signed [31:0]   linear_velocity,
  output logic signed [31:0]   angular_velocity,
  output logic signed [31:0]   tracking_error,
  output logic                 command_valid
);

  localparam logic [30:0] CX_RST  = 31'(64'd6 << FRAC_BITS);
  localparam logic [30:0] R_RST   = 31'(64'd6 << FRAC_BITS);
  localparam logic [31:0] CS_RST  = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] GP_RST  = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [30:0] OBS_RST = 31'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);

  logic [30:0]        center_x, radius, obstacle_range;
  logic signed [31:0] cruise_speed, gain_p, gain_i, gain_d;

  logic signed [31:0]      stored_x, stored_y, previous_error;
  logic                    obstacle_latch;
  logic signed [INT_W-1:0] error_integral;

  logic [31:0]              dx, ady;
  logic signed [31:0]       err;
  logic signed [32:0]       diff;
  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [2*MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, prod_ext;
  logic [63:0]              rem, root, bitv, sq_t;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= CX_RST;
      radius         <= R_RST;
      cruise_speed   <= CS_RST;
      gain_p         <= GP_RST;
      gain_i         <= '0;
      gain_d         <= '0;
      obstacle_range <= OBS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: center_x       <= cfg_data[30:0];
        CFG_RADIUS:   radius         <= cfg_data[30:0];
        CFG_CRUISE:   cruise_speed   <= cfg_data;
        CFG_GAIN_P:   gain_p         <= cfg_data;
        CFG_GAIN_I:   gain_i         <= cfg_data;
        CFG_GAIN_D:   gain_d         <= cfg_data;
        CFG_OBST:     obstacle_range <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // geometry and integral saturation
  logic signed [33:0] xs, ys, pcx, ncx, r34, dx_w, ady_w, line_w, arc_w;
  logic               left, right;
  logic signed [48:0] integ_sum;
  logic signed [INT_W-1:0] integ_sat;

  always_comb begin
    xs     = {{2{stored_x[31]}}, stored_x};
    ys     = {{2{stored_y[31]}}, stored_y};
    pcx    = {3'b000, center_x};
    ncx    = -pcx;
    r34    = {3'b000, radius};
    left   = xs < ncx;
    right  = xs > pcx;
    dx_w   = left ? (ncx - xs) : (xs - pcx);
    ady_w  = stored_y[31] ? -ys : ys;
    line_w = (ys > 34'sd0) ? (ys - r34) : (-r34 - ys);
    arc_w  = {2'b00, root[31:0]} - r34;
    integ_sum = {error_integral[INT_W-1], error_integral} + 49'(err);
    if (integ_sum > 49'sh0_7FFF_FFFF_FFFF)       integ_sat = {1'b0, {(INT_W-1){1'b1}}};
    else if (integ_sum < -49'sh0_8000_0000_0000) integ_sat = {1'b1, {(INT_W-1){1'b0}}};
    else                                         integ_sat = integ_sum[INT_W-1:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_x       <= '0;
      stored_y       <= '0;
      obstacle_latch <= 1'b0;
      error_integral <= '0;
      previous_error <= '0;
    end else begin
      if (cmd.capture) begin
        case (opcode)
          OP_RANGE: if (range_sample < obstacle_range) obstacle_latch <= 1'b1;
          OP_POSE: begin
            stored_x <= pose_x;
            stored_y <= pose_y;
          end
          default: ;
        endcase
      end
      if (cmd.pid_upd) begin
        error_integral <= integ_sat;
        previous_error <= err;
      end
    end
  end

  // working registers
  always_comb begin
    case (cmd.mul_sel)
      MUL_DX:  begin ma = {1'b0, dx};  mb = {1'b0, dx};  end
      MUL_DY:  begin ma = {1'b0, ady}; mb = {1'b0, ady}; end
      MUL_PE:  begin ma = 33'(gain_p); mb = 33'(err);    end
      MUL_ILO: begin ma = 33'(gain_i); mb = {9'd0, error_integral[IHI_SHIFT-1:0]}; end
      MUL_IHI: begin
        ma = 33'(gain_i);
        mb = 33'(signed'(error_integral[INT_W-1:IHI_SHIFT]));
      end
      MUL_DD:  begin ma = 33'(gain_d); mb = diff; end
      default: begin ma = '0; mb = '0; end
    endcase
    prod_ext = ACC_W'(prod);
    sq_t     = root + bitv;
  end

  always_ff @(posedge clk) begin
    if (cmd.geom) begin
      dx  <= dx_w[31:0];
      ady <= ady_w[31:0];
      err <= sat32(line_w);
    end
    if (cmd.err_arc) err <= sat32(arc_w);
    if (cmd.pid_upd) diff <= 33'(err) - 33'(previous_error);
    if (cmd.mul_en) prod <= ma * mb;
    case (cmd.acc_op)
      ACC_LOAD:   acc <= prod_ext;
      ACC_ADD:    acc <= acc + prod_ext;
      ACC_ADD_SH: acc <= acc + (prod_ext <<< IHI_SHIFT);
      default: ;
    endcase
    if (cmd.sq_init) begin
      rem  <= acc[63:0];
      root <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (cmd.sq_step) begin
      if (rem >= sq_t) begin
        rem  <= rem - sq_t;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  // result register
  logic signed [ACC_W-1:0] shifted;
  logic signed [31:0]      ang_sat;

  always_comb begin
    shifted = acc >>> FRAC_BITS;
    if (shifted > ACC_W'(32'sh7FFF_FFFF))      ang_sat = 32'sh7FFF_FFFF;
    else if (shifted < ACC_W'(32'sh8000_0000)) ang_sat = 32'sh8000_0000;
    else                                       ang_sat = shifted[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      linear_velocity  <= cmd.out_zero ? '0 : cruise_speed;
      angular_velocity <= cmd.out_zero ? '0 : ang_sat;
      tracking_error   <= cmd.out_zero ? '0 : err;
      command_valid    <= !cmd.out_zero;
    end
  end

  // status: obstacle latch, arc decision from the stored pose (valid in the geometry cycle), result-full
  assign status.latched  = obstacle_latch;
  assign status.arc      = left || right;
  assign status.out_full = out_valid;

endmodule
